// ===== src/fsqrt_pkg.sv =====
// fsqrt_pkg: shared types, constants and recurrence step for the square root pipeline
// no dependencies
`timescale 1ns / 1ps
package fsqrt_pkg;

  localparam int unsigned STEPS = 26;
  localparam int unsigned STEPS_PER_STAGE = 2;
  localparam int unsigned NUM_STAGES = STEPS / STEPS_PER_STAGE;
  localparam logic [7:0] EXP_BIAS = 8'd127;
  localparam logic [31:0] HIDDEN_BIT = 32'h0080_0000;
  localparam logic [31:0] FRAC_MASK = 32'h007f_ffff;
  localparam logic [31:0] FIRST_BIT = 32'h0200_0000;

  typedef struct packed {
    logic [7:0]  e8;
    logic [31:0] rem;
    logic [31:0] acc;
    logic [31:0] bitv;
  } fsqrt_work_t;

  function automatic fsqrt_work_t fsqrt_step(input fsqrt_work_t w);
    fsqrt_work_t r;
    logic [31:0] trial;
    logic [31:0] dbl;
    r = w;
    trial = w.acc + w.bitv;
    dbl = w.rem + w.rem;
    r.rem = dbl;
    if (trial <= dbl) begin
      r.acc = trial + w.bitv;
      r.rem = dbl - trial;
    end
    r.bitv = w.bitv >> 1;
    return r;
  endfunction

endpackage

// ===== src/fsqrt_stage.sv =====
// fsqrt_stage: one pipeline register holding two steps of the root recurrence
// depends on fsqrt_pkg
`timescale 1ns / 1ps
module fsqrt_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  fsqrt_pkg::fsqrt_work_t in_work,
  output logic                  out_valid,
  input  logic                  out_ready,
  output fsqrt_pkg::fsqrt_work_t out_work
);
  import fsqrt_pkg::*;

  fsqrt_work_t work_next;

  always_comb begin
    work_next = in_work;
    for (int i = 0; i < STEPS_PER_STAGE; i++) begin
      work_next = fsqrt_step(work_next);
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_work <= work_next;
    end
  end

endmodule

// ===== src/float32_square_root.sv =====
// float32_square_root: pipelined single-precision square root, round to nearest
// depends on fsqrt_pkg and fsqrt_stage
//
// usage:
//   input channel operand_valid / operand_ready / operand_bits carries one
//   32-bit operand word; the sign bit is ignored
//   output channel root_valid / root_ready / root_bits carries the root word
//   a word moves when valid and ready are both high at a rising clock edge
// pipeline: 13 recurrence stages of two digit steps each, then the rounding and
//   exponent output register
// throughput: one word per cycle unless a low root_ready stalls the pipe; the
//   per-stage add, compare and subtract chain of two digit steps sets the clock
// reset: rst is synchronous and clears every stage valid bit, so the pipe
//   empties at once
// stall: when root_ready is low the output register holds its word; each
//   stage still fills any bubble ahead of it, so operand_ready stays high
//   until every stage holds a word
`timescale 1ns / 1ps
module float32_square_root (
  input  logic        clk,
  input  logic        rst,
  input  logic        operand_valid,
  output logic        operand_ready,
  input  logic [31:0] operand_bits,
  output logic        root_valid,
  input  logic        root_ready,
  output logic [31:0] root_bits
);
  import fsqrt_pkg::*;

  logic        stg_valid [NUM_STAGES+1];
  logic        stg_ready [NUM_STAGES+1];
  fsqrt_work_t stg_work  [NUM_STAGES+1];

  logic [7:0]  e8;
  logic [31:0] mant;
  fsqrt_work_t first_work;
  logic [31:0] fin_acc;
  logic [7:0]  fin_e8;
  logic [31:0] frac;
  logic [7:0]  new_exp;
  logic [31:0] root_next;
  logic        out_ready;

  // unbias and align the significand
  always_comb begin
    e8 = operand_bits[30:23] - EXP_BIAS;
    mant = (operand_bits & FRAC_MASK) | HIDDEN_BIT;
    mant = e8[0] ? (mant << 2) : (mant << 1);
    first_work.e8 = e8;
    first_work.rem = mant;
    first_work.acc = 32'd0;
    first_work.bitv = FIRST_BIT;
  end

  assign stg_work[0] = first_work;
  assign stg_valid[0] = operand_valid;
  assign operand_ready = stg_ready[0];

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    fsqrt_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stg_valid[g]),
      .in_ready  (stg_ready[g]),
      .in_work   (stg_work[g]),
      .out_valid (stg_valid[g+1]),
      .out_ready (stg_ready[g+1]),
      .out_work  (stg_work[g+1])
    );
  end

  // rounding and exponent
  always_comb begin
    fin_acc = stg_work[NUM_STAGES].acc;
    fin_e8 = stg_work[NUM_STAGES].e8;
    frac = ((fin_acc >> 3) ^ HIDDEN_BIT) + {31'd0, fin_acc[2]};
    new_exp = {fin_e8[7], fin_e8[7:1]} + EXP_BIAS;
    root_next = {1'b0, new_exp, 23'd0} | frac;
  end

  assign out_ready = !root_valid || root_ready;
  assign stg_ready[NUM_STAGES] = out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_valid <= 1'b0;
    end else if (out_ready) begin
      root_valid <= stg_valid[NUM_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && stg_valid[NUM_STAGES]) begin
      root_bits <= root_next;
    end
  end

endmodule
